// File: sv/rssp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rssp_pkg
// Shared constants and register indexes for the point rotation, shading and
// projection pipeline.
// ----------------------------------------------------------------------------
package rssp_pkg;

	localparam int CFG_W = 48;
	localparam int CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROT_X   = 3'd0,
		REG_ROT_Y   = 3'd1,
		REG_ROT_Z   = 3'd2,
		REG_LIGHT   = 3'd3,
		REG_CENTER  = 3'd4,
		REG_SCALE   = 3'd5,
		REG_RADIUS  = 3'd6,
		REG_SHADE   = 3'd7
	} cfg_idx_t;

endpackage
`default_nettype wire

// File: sv/rotate_shade_project_point.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rotate_shade_project_point
// Rotates one model point about z, x and y, derives a shade index from the
// distance to a light point and projects it to a jittered screen pixel.
//
// Usage: the input channel carries one point, one cell jitter pair and the
// cell position per transfer; the output channel carries one pixel, one shade
// index and the last-point mark per transfer. Both use valid and stall.
// Throughput is one item per cycle: every stage is a register with its own
// valid bit, and the whole pipeline advances whenever the output register is
// empty or is being taken. When the receiver stalls with a full output
// register, every stage holds and the input is stalled for as long as that
// lasts. Reset clears all valid bits and loads the register defaults. The
// configuration port writes one register per enabled cycle. It must only be
// written while the pipeline is empty; the block itself does not enforce
// this.
// ----------------------------------------------------------------------------
module rotate_shade_project_point (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             cfg_we,
	input  wire [rssp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire [rssp_pkg::CFG_W-1:0]       cfg_data,
	input  wire                             in_valid,
	output logic                            in_stall,
	input  wire signed [15:0]               pos_x,
	input  wire signed [15:0]               pos_y,
	input  wire signed [15:0]               pos_z,
	input  wire signed [15:0]               jitter_x,
	input  wire signed [15:0]               jitter_y,
	input  wire [1:0]                       cell_col,
	input  wire [1:0]                       cell_row,
	input  wire                             is_last_in,
	output logic                            out_valid,
	input  wire                             out_stall,
	output logic signed [15:0]              screen_x,
	output logic signed [15:0]              screen_y,
	output logic [7:0]                      shade_index,
	output logic                            is_last_out
);
	import rssp_pkg::*;

	localparam int NS = 11;

	logic [31:0] rot_x_q, rot_y_q, rot_z_q, center_q;
	logic [47:0] light_q;
	logic [23:0] scale_q;
	logic [13:0] radius_q;
	logic [16:0] shade_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_x_q  <= 32'd16384;
			rot_y_q  <= 32'd16384;
			rot_z_q  <= 32'd16384;
			light_q  <= '0;
			center_q <= '0;
			scale_q  <= 24'd256;
			radius_q <= 14'd3203;
			shade_q  <= 17'd2227;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				REG_ROT_X:  rot_x_q  <= cfg_data[31:0];
				REG_ROT_Y:  rot_y_q  <= cfg_data[31:0];
				REG_ROT_Z:  rot_z_q  <= cfg_data[31:0];
				REG_LIGHT:  light_q  <= cfg_data[47:0];
				REG_CENTER: center_q <= cfg_data[31:0];
				REG_SCALE:  scale_q  <= cfg_data[23:0];
				REG_RADIUS: radius_q <= cfg_data[13:0];
				REG_SHADE:  shade_q  <= cfg_data[16:0];
				default: ;
			endcase
		end
	end

	logic signed [15:0] sx, cx, sy, cy, sz, cz;
	assign sx = rot_x_q[31:16];
	assign cx = rot_x_q[15:0];
	assign sy = rot_y_q[31:16];
	assign cy = rot_y_q[15:0];
	assign sz = rot_z_q[31:16];
	assign cz = rot_z_q[15:0];

	logic [NS:1] v_q;
	logic        adv;
	assign adv       = !v_q[NS] || !out_stall;
	assign in_stall  = !adv;
	assign out_valid = v_q[NS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_q <= '0;
		else if (adv)
			v_q <= {v_q[NS-1:1], in_valid};
	end

	// Side-band data carried alongside the arithmetic.
	logic signed [15:0] jx_s1, jx_s2, jx_s3, jx_s4, jx_s5, jx_s6, jx_s7;
	logic signed [15:0] jy_s1, jy_s2, jy_s3, jy_s4, jy_s5, jy_s6, jy_s7;
	logic [1:0]  cc_s1, cc_s2, cc_s3, cc_s4, cc_s5, cc_s6, cc_s7;
	logic [1:0]  cr_s1, cr_s2, cr_s3, cr_s4, cr_s5, cr_s6, cr_s7;
	logic [NS:1] last_q;

	// Stages 1-3: input registers, then rotation about z.
	logic signed [15:0] px_s1, py_s1, pz_s1, pz_s2, pz_s3;
	logic signed [31:0] m1_s2, m2_s2, m3_s2, m4_s2;
	logic signed [18:0] ax_s3, ay_s3;
	// Stage 4/5: rotation about x.
	logic signed [34:0] m5_s4, m6_s4, m7_s4, m8_s4;
	logic signed [18:0] ax_s4, ax_s5;
	logic signed [21:0] by_s5, bz_s5;
	// Stage 6/7: rotation about y.
	logic signed [37:0] m9_s6, m10_s6, m11_s6, m12_s6;
	logic signed [21:0] by_s6, by_s7;
	logic signed [24:0] az_s7, rx_s7;
	// Stage 8: squares, base products, radius, offsets.
	logic signed [51:0] dxx_s8, dyy_s8, dzz_s8;
	logic signed [48:0] bpx_s8, bpy_s8;
	logic signed [33:0] rad_s8;
	logic signed [25:0] offx_s8, offy_s8;
	// Stage 9: sum, bases, offset products.
	logic [53:0] d2_s9;
	logic signed [48:0] basex_s9, basey_s9;
	logic signed [58:0] opx_s9, opy_s9;
	// Stage 10: shade, pixels.
	logic [61:0] sh_s10;
	logic signed [15:0] pxx_s10, pyy_s10;
	logic [7:0] cnt_s10;
	// Output.
	logic signed [15:0] ox_s11, oy_s11;
	logic [7:0] osh_s11;

	function automatic logic signed [63:0] trunc_shr(input logic signed [87:0] v,
		input int s);
		logic [87:0] a;
		a = v[87] ? 88'(-v) : 88'(v);
		a = a >> s;
		return v[87] ? -64'(a) : 64'(a);
	endfunction

	function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
		if (v > 64'sd32767) return 16'sh7fff;
		if (v < -64'sd32768) return 16'sh8000;
		return v[15:0];
	endfunction

	logic signed [20:0] dx_c, dy_c, dz_c;
	logic signed [33:0] rad_c;
	logic signed [7:0]  rmin_c, rmax_c;
	logic signed [25:0] offx_c, offy_c;
	logic signed [48:0] bsx_c, bsy_c;
	logic signed [87:0] totx_c, toty_c;
	logic [61:0] shp_c;

	always_comb begin
		rmin_c = {1'b0, radius_q[6:0]};
		rmax_c = {1'b0, radius_q[13:7]};
		rad_c  = 34'((35'(az_s7) + 35'sd16384) * 35'(rmax_c - rmin_c))
			+ (34'(rmin_c) <<< 15);
		offx_c = 26'(($signed({1'b0, cc_s7}) - 3'sd1) * 26'sd4194304)
			+ 26'(jx_s7 * $signed({1'b0, shade_q[8:0]}));
		offy_c = 26'(($signed({1'b0, cr_s7}) - 3'sd1) * 26'sd4194304)
			+ 26'(jy_s7 * $signed({1'b0, shade_q[8:0]}));
		dx_c = 21'(rx_s7 - 25'(signed'(light_q[15:0])));
		dy_c = 21'(25'(by_s7) - 25'(signed'(light_q[31:16])));
		dz_c = 21'(az_s7 - 25'(signed'(light_q[47:32])));
		bsx_c = 49'(trunc_shr(88'(bpx_s8) + (88'(signed'(center_q[15:0])) <<< 23), 23));
		bsy_c = 49'(trunc_shr(88'(bpy_s8) + (88'(signed'(center_q[31:16])) <<< 23), 23));
		totx_c = (88'(basex_s9) <<< 37) + 88'(opx_s9);
		toty_c = (88'(basey_s9) <<< 37) + 88'(opy_s9);
		shp_c  = 62'(d2_s9) * 62'(shade_q[16:9]);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			last_q <= {last_q[NS-1:1], is_last_in};
			px_s1 <= pos_x; py_s1 <= pos_y; pz_s1 <= pos_z;
			jx_s1 <= jitter_x; jy_s1 <= jitter_y; cc_s1 <= cell_col; cr_s1 <= cell_row;
			jx_s2 <= jx_s1; jx_s3 <= jx_s2; jx_s4 <= jx_s3; jx_s5 <= jx_s4;
			jx_s6 <= jx_s5; jx_s7 <= jx_s6;
			jy_s2 <= jy_s1; jy_s3 <= jy_s2; jy_s4 <= jy_s3; jy_s5 <= jy_s4;
			jy_s6 <= jy_s5; jy_s7 <= jy_s6;
			cc_s2 <= cc_s1; cc_s3 <= cc_s2; cc_s4 <= cc_s3; cc_s5 <= cc_s4;
			cc_s6 <= cc_s5; cc_s7 <= cc_s6;
			cr_s2 <= cr_s1; cr_s3 <= cr_s2; cr_s4 <= cr_s3; cr_s5 <= cr_s4;
			cr_s6 <= cr_s5; cr_s7 <= cr_s6;

			m1_s2 <= px_s1 * cz; m2_s2 <= py_s1 * sz;
			m3_s2 <= px_s1 * sz; m4_s2 <= py_s1 * cz;
			pz_s2 <= pz_s1;
			ax_s3 <= 19'((33'(m1_s2) - 33'(m2_s2)) >>> 14);
			ay_s3 <= 19'((33'(m3_s2) + 33'(m4_s2)) >>> 14);
			pz_s3 <= pz_s2;

			m5_s4 <= ay_s3 * cx; m6_s4 <= 35'(pz_s3) * sx;
			m7_s4 <= ay_s3 * sx; m8_s4 <= 35'(pz_s3) * cx;
			ax_s4 <= ax_s3;
			by_s5 <= 22'((36'(m5_s4) - 36'(m6_s4)) >>> 14);
			bz_s5 <= 22'((36'(m7_s4) + 36'(m8_s4)) >>> 14);
			ax_s5 <= ax_s4;

			m9_s6 <= bz_s5 * cy; m10_s6 <= 38'(ax_s5) * sy;
			m11_s6 <= bz_s5 * sy; m12_s6 <= 38'(ax_s5) * cy;
			by_s6 <= by_s5;
			az_s7 <= 25'((39'(m9_s6) - 39'(m10_s6)) >>> 14);
			rx_s7 <= 25'((39'(m11_s6) + 39'(m12_s6)) >>> 14);
			by_s7 <= by_s6;

			dxx_s8 <= 52'(dx_c * dx_c); dyy_s8 <= 52'(dy_c * dy_c);
			dzz_s8 <= 52'(dz_c * dz_c);
			bpx_s8 <= 49'(rx_s7) * $signed({1'b0, scale_q});
			bpy_s8 <= 49'(by_s7) * $signed({1'b0, scale_q});
			rad_s8 <= rad_c; offx_s8 <= offx_c; offy_s8 <= offy_c;

			d2_s9 <= 54'(dxx_s8) + 54'(dyy_s8) + 54'(dzz_s8);
			basex_s9 <= bsx_c; basey_s9 <= bsy_c;
			opx_s9 <= 59'(offx_s8) * 59'(rad_s8);
			opy_s9 <= 59'(offy_s8) * 59'(rad_s8);

			sh_s10 <= shp_c;
			cnt_s10 <= shade_q[16:9];
			pxx_s10 <= sat16(trunc_shr(totx_c, 37));
			pyy_s10 <= sat16(trunc_shr(toty_c, 37));

			ox_s11 <= pxx_s10; oy_s11 <= pyy_s10;
			osh_s11 <= ((32'(sh_s10 >> 30) + 32'd1) > 32'(cnt_s10)) ? cnt_s10
				: 8'((sh_s10 >> 30) + 62'd1);
		end
	end

	assign screen_x    = ox_s11;
	assign screen_y    = oy_s11;
	assign shade_index = osh_s11;
	assign is_last_out = last_q[NS];

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(screen_x) && $stable(shade_index))
		else $error("output changed while stalled");
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output back-pressure");
	a_move: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> v_q[1])
		else $error("accepted item lost at stage one");

endmodule
`default_nettype wire
